// ----- src/deq_pkg.sv -----
package deq_pkg;

   localparam int DATA_W = 32;

   localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

// ----- src/deq_ifs.sv -----
interface deq_req_if;
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   logic                     ok;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] back_value;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output popped_value, output ok, output front_value,
                   output back_value, output is_empty, output is_full, input ready);
   modport sink   (input valid, input popped_value, input ok, input front_value,
                   input back_value, input is_empty, input is_full, output ready);
endinterface

// ----- src/deq_ram.sv -----
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- src/double_ended_queue_top.sv -----
// Double-ended queue of DEPTH signed 32-bit entries in a circular buffer held in a
// single-port-write, single-port-read RAM. Each request pushes or pops at either
// end and returns one response with the popped value (-1 for pushes and refused
// operations), a done flag, the front and back values after the operation (-1 when
// empty) and the empty and full flags. The front and back values are kept in
// registers, so pushes, refused operations and pops that leave zero or one element
// are answered without a RAM read; a pop that leaves two or more elements passes
// through ST_READ, where the RAM read fetches the new end value. The response sits
// in an output register; a request is taken only in ST_IDLE, once that register is
// empty or in the same cycle as its response is taken, never while it stalls.
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   deq_req_if.sink  req_bus,
   deq_rsp_if.source rsp_bus
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
   localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);
   localparam logic [OCC_W-1:0] OCC_TWO  = OCC_W'(2);

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
   endfunction

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // end values and pending pop
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] back_ff, back_in;
   logic signed [DATA_W-1:0] pend_popped_ff, pend_popped_in;
   logic                     pend_front_ff, pend_front_in;

   // response register
   logic signed [DATA_W-1:0] out_popped_ff, out_popped_in;
   logic                     out_ok_ff, out_ok_in;
   logic signed [DATA_W-1:0] out_front_ff, out_front_in;
   logic signed [DATA_W-1:0] out_back_ff, out_back_in;
   logic                     out_empty_ff, out_empty_in;
   logic                     out_full_ff, out_full_in;
   logic                     load_out;

   // RAM port signals
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic accept;

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // take a request only when idle and the response slot frees up this cycle
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   // operation decode, pointer update, response build
   always_comb begin
      logic is_empty_now;
      logic is_full_now;
      logic empty_after;

      is_empty_now = (occ_ff == '0);
      is_full_now  = (occ_ff == OCC_FULL);
      empty_after  = 1'b0;

      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      pend_popped_in = pend_popped_ff;
      pend_front_in  = pend_front_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = req_bus.data_in;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;

      load_out      = 1'b0;
      out_popped_in = NEG_ONE;
      out_ok_in     = 1'b0;
      out_front_in  = front_ff;
      out_back_in   = back_ff;
      out_empty_in  = 1'b0;
      out_full_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_out = 1'b1;
               unique case (cmd_type'(req_bus.cmd))
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (!is_full_now) begin
                        out_ok_in = 1'b1;
                        occ_in    = occ_ff + OCC_ONE;
                        ram_wr_en = 1'b1;
                        if (is_empty_now) begin
                           head_in     = '0;
                           tail_in     = '0;
                           ram_wr_addr = '0;
                           front_in    = req_bus.data_in;
                           back_in     = req_bus.data_in;
                        end else if (cmd_type'(req_bus.cmd) == CMD_PUSH_FRONT) begin
                           head_in     = wrap_dec(head_ff);
                           ram_wr_addr = head_in;
                           front_in    = req_bus.data_in;
                        end else begin
                           tail_in     = wrap_inc(tail_ff);
                           ram_wr_addr = tail_in;
                           back_in     = req_bus.data_in;
                        end
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (!is_empty_now) begin
                        out_ok_in = 1'b1;
                        occ_in    = occ_ff - OCC_ONE;
                        if (cmd_type'(req_bus.cmd) == CMD_POP_FRONT) begin
                           out_popped_in = front_ff;
                        end else begin
                           out_popped_in = back_ff;
                        end
                        if (occ_ff == OCC_ONE) begin
                           // last element gone: pointers return home
                           head_in = '0;
                           tail_in = '0;
                        end else if (cmd_type'(req_bus.cmd) == CMD_POP_FRONT) begin
                           head_in = wrap_inc(head_ff);
                           if (occ_ff == OCC_TWO) begin
                              front_in = back_ff;
                           end else begin
                              // fetch the new front from the RAM
                              load_out       = 1'b0;
                              ram_rd_en      = 1'b1;
                              ram_rd_addr    = head_in;
                              pend_popped_in = front_ff;
                              pend_front_in  = 1'b1;
                              state_in       = ST_READ;
                           end
                        end else begin
                           tail_in = wrap_dec(tail_ff);
                           if (occ_ff == OCC_TWO) begin
                              back_in = front_ff;
                           end else begin
                              // fetch the new back from the RAM
                              load_out       = 1'b0;
                              ram_rd_en      = 1'b1;
                              ram_rd_addr    = tail_in;
                              pend_popped_in = back_ff;
                              pend_front_in  = 1'b0;
                              state_in       = ST_READ;
                           end
                        end
                     end
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase

               empty_after  = (occ_in == '0);
               out_empty_in = empty_after;
               out_full_in  = (occ_in == OCC_FULL);
               out_front_in = empty_after ? NEG_ONE : front_in;
               out_back_in  = empty_after ? NEG_ONE : back_in;
            end
         end
         ST_READ: begin
            // capture the fetched end value and finish the pop
            load_out      = 1'b1;
            state_in      = ST_IDLE;
            if (pend_front_ff) begin
               front_in = ram_rd_data;
            end else begin
               back_in = ram_rd_data;
            end
            out_popped_in = pend_popped_ff;
            out_ok_in     = 1'b1;
            out_front_in  = front_in;
            out_back_in   = back_in;
            out_empty_in  = 1'b0;
            out_full_in   = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the response until taken
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      back_ff        <= back_in;
      pend_popped_ff <= pend_popped_in;
      pend_front_ff  <= pend_front_in;
      if (load_out) begin
         out_popped_ff <= out_popped_in;
         out_ok_ff     <= out_ok_in;
         out_front_ff  <= out_front_in;
         out_back_ff   <= out_back_in;
         out_empty_ff  <= out_empty_in;
         out_full_ff   <= out_full_in;
      end
   end

   // drive the response channel
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.popped_value = out_popped_ff;
   assign rsp_bus.ok           = out_ok_ff;
   assign rsp_bus.front_value  = out_front_ff;
   assign rsp_bus.back_value   = out_back_ff;
   assign rsp_bus.is_empty     = out_empty_ff;
   assign rsp_bus.is_full      = out_full_ff;

endmodule

// ----- dv/tb_double_ended_queue_top.sv -----
module tb_double_ended_queue_top;
   import deq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_CMDS = 1400;
   localparam int CALM_CMDS   = 150;   // tail of the run without random gaps or ready stalls
   localparam int MAX_REPORTS = 10;

   typedef struct {
      cmd_type                  op;
      logic signed [DATA_W-1:0] value;
      bit                       hold;  // wait for all responses before sending
   } deq_cmd_type;

   typedef struct {
      logic signed [DATA_W-1:0] popped;
      logic                     ok;
      logic signed [DATA_W-1:0] front;
      logic signed [DATA_W-1:0] back;
      logic                     empty;
      logic                     full;
   } deq_rsp_type;

   logic clock;
   logic reset;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_top #(.DEPTH(DEPTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   deq_cmd_type cmd_queue[$];
   deq_rsp_type predicted_rsp[$];
   deq_cmd_type cur_cmd;
   int          mismatches = 0;
   int          gap_left   = 0;
   int          gap_odds   = 2;
   int          stall_left = 0;
   int          stall_odds = 2;

   // shadow copy of the deque contents
   logic signed [DATA_W-1:0] slot_mem [DEPTH];
   logic [3:0]               head_ptr;   // 4-bit pointers wrap at DEPTH = 16
   logic [3:0]               tail_ptr;
   logic [4:0]               fill_count;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // apply one command to the shadow deque and return its response
   function automatic deq_rsp_type deque_apply(input cmd_type op,
                                               input logic signed [DATA_W-1:0] v);
      deq_rsp_type r;
      r.popped = NEG_ONE;
      r.ok     = 1'b0;
      if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
         if (fill_count < DEPTH) begin
            if (fill_count == 0) begin
               head_ptr    = '0;
               tail_ptr    = '0;
               slot_mem[0] = v;
            end else if (op == CMD_PUSH_FRONT) begin
               head_ptr           = head_ptr - 1'b1;
               slot_mem[head_ptr] = v;
            end else begin
               tail_ptr           = tail_ptr + 1'b1;
               slot_mem[tail_ptr] = v;
            end
            fill_count++;
            r.ok = 1'b1;
         end
      end else if (fill_count > 0) begin
         if (op == CMD_POP_FRONT) begin
            r.popped = slot_mem[head_ptr];
            head_ptr = head_ptr + 1'b1;
         end else begin
            r.popped = slot_mem[tail_ptr];
            tail_ptr = tail_ptr - 1'b1;
         end
         fill_count--;
         if (fill_count == 0) begin
            head_ptr = '0;
            tail_ptr = '0;
         end
         r.ok = 1'b1;
      end
      r.empty = (fill_count == 0);
      r.full  = (fill_count == DEPTH);
      r.front = r.empty ? NEG_ONE : slot_mem[head_ptr];
      r.back  = r.empty ? NEG_ONE : slot_mem[tail_ptr];
      return r;
   endfunction

   // mostly random words, sometimes the extremes
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return NEG_ONE;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_cmd(input cmd_type op, input logic signed [DATA_W-1:0] v,
                                   input bit hold);
      deq_cmd_type c;
      c.op      = op;
      c.value   = v;
      c.hold    = hold;
      cmd_queue = {cmd_queue, c};
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
   endtask

   // fill the command queue, then wait for the run to drain
   initial begin
      int      made;
      int      run_len;
      int      push_pct;
      bit      is_push;
      bit      at_back;
      cmd_type op;

      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_PUSH_FRONT;
      req_bus.data_in = '0;
      rsp_bus.ready   = 1'b0;
      fill_count      = '0;
      head_ptr        = '0;
      tail_ptr        = '0;

      // directed: pops on empty, single-element round trips, fill, refused pushes, pops from full
      add_cmd(CMD_POP_FRONT, 32'sh1234_5678, 1'b0);
      add_cmd(CMD_POP_BACK, NEG_ONE, 1'b0);
      add_cmd(CMD_PUSH_BACK, 32'sh7fff_ffff, 1'b0);
      add_cmd(CMD_POP_FRONT, '0, 1'b0);
      add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 1'b0);
      add_cmd(CMD_POP_BACK, '0, 1'b0);
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0: add_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff - i, i == 0);
            1: add_cmd(CMD_PUSH_BACK, 32'sh8000_0000 + i, 1'b0);
            2: add_cmd(CMD_PUSH_FRONT, (i[0] ? 32'sh5555_5555 : 32'shaaaa_aaaa), 1'b0);
            default: add_cmd(CMD_PUSH_BACK, NEG_ONE - i, 1'b0);
         endcase
      end
      add_cmd(CMD_PUSH_FRONT, 32'sh0bad_cafe, 1'b0);
      add_cmd(CMD_PUSH_BACK, 32'sh0bad_beef, 1'b0);
      add_cmd(CMD_POP_FRONT, '0, 1'b0);
      add_cmd(CMD_POP_BACK, '0, 1'b1);

      // random: runs biased toward filling, draining or churning the deque
      made = 0;
      while (made < RANDOM_CMDS) begin
         case ($urandom_range(0, 3))
            0:       push_pct = 85;
            1:       push_pct = 15;
            2:       push_pct = 50;
            default: push_pct = 65;
         endcase
         run_len = $urandom_range(8, 48);
         repeat (run_len) begin
            is_push = ($urandom_range(0, 99) < push_pct);
            at_back = $urandom_range(0, 1);
            if (is_push) op = at_back ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else         op = at_back ? CMD_POP_BACK : CMD_POP_FRONT;
            add_cmd(op, pick_value(), $urandom_range(0, 99) == 0);
            made++;
         end
      end

      @(negedge reset);
      while (cmd_queue.size() != 0 || req_bus.valid || predicted_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // driver: present commands, predict each accepted transaction
   always @(posedge clock) begin
      logic        drive;
      deq_rsp_type pred;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         drive = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            pred          = deque_apply(cur_cmd.op, cur_cmd.value);
            predicted_rsp = {predicted_rsp, pred};
            drive = 1'b0;
            if ($urandom_range(0, 49) == 0) gap_odds = $urandom_range(0, 3);
         end
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].hold && predicted_rsp.size() != 0)) begin
               cur_cmd = cmd_queue[0];
               cmd_queue.delete(0);
               drive   = 1'b1;
               req_bus.cmd     <= cur_cmd.op;
               req_bus.data_in <= cur_cmd.value;
               if (cmd_queue.size() > CALM_CMDS && $urandom_range(1, 12) <= gap_odds)
                  gap_left = $urandom_range(1, 16);
            end
         end
         req_bus.valid <= drive;
      end
   end

   // monitor: compare each response transaction against the oldest prediction
   always @(posedge clock) begin
      deq_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: popped %h front %h back %h",
                           rsp_bus.popped_value, rsp_bus.front_value, rsp_bus.back_value);
            end else begin
               want = predicted_rsp[0];
               predicted_rsp.delete(0);
               check_field("popped_value", want.popped, rsp_bus.popped_value);
               check_field("ok", want.ok, rsp_bus.ok);
               check_field("front_value", want.front, rsp_bus.front_value);
               check_field("back_value", want.back, rsp_bus.back_value);
               check_field("is_empty", want.empty, rsp_bus.is_empty);
               check_field("is_full", want.full, rsp_bus.is_full);
            end
            if ($urandom_range(0, 49) == 0) stall_odds = $urandom_range(0, 3);
         end
         // hold ready low during a stall burst
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (cmd_queue.size() > CALM_CMDS && $urandom_range(1, 12) <= stall_odds)
               stall_left = $urandom_range(1, 16);
         end
      end
   end

endmodule

// ----- double_ended_queue_top.f -----
src/deq_pkg.sv
src/deq_ifs.sv
src/deq_ram.sv
src/double_ended_queue_top.sv
dv/tb_double_ended_queue_top.sv
